@@ design/bdp_pkg.sv @@
// Shared constants, types and helpers for the box downscaler.
`timescale 1ns / 1ps
package bdp_pkg;

    localparam int DEF_MAX_SRC_DIM = 1024;
    localparam int DEF_MAX_DST_DIM = 256;
    localparam int DEF_MAX_FACTOR  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SRC_CFG_W  = 11;
    localparam int DST_CFG_W  = 9;

    localparam logic [SRC_CFG_W-1:0] SRC_DIM_RESET = 11'd64;
    localparam logic [DST_CFG_W-1:0] DST_DIM_RESET = 9'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } bdp_reg_t;

    typedef struct packed {
        logic first;
        logic emit;
        logic last;
    } bdp_flags_t;

    // Truncating divide by 255 for a 16-bit value.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] p;
        p = {17'd0, x} * 33'h08081;
        return p[30:23];
    endfunction

endpackage

@@ design/bdp_ram.sv @@
// Generic single-port-write, registered-read memory.
`timescale 1ns / 1ps
module bdp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ design/bdp_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bdp_div #(
    parameter int NW  = 16,
    parameter int DWD = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [NW-1:0]  dividend,
    input  logic [DWD-1:0] divisor,
    output logic           done,
    output logic [NW-1:0]  quotient
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    num_reg;
    logic [DWD-1:0]   rem_reg;
    logic [DWD-1:0]   den_reg;
    logic [DWD:0]     trial;
    logic             ge;
    logic [DWD:0]     rem_sub;

    always_comb
    begin
        trial   = {rem_reg, num_reg[NW-1]};
        ge      = trial >= {1'b0, den_reg};
        rem_sub = ge ? (trial - {1'b0, den_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= rem_sub[DWD-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;
endmodule

@@ design/bdp_front.sv @@
// Front end: configuration, frame setup, pixel classification and item queue.
`timescale 1ns / 1ps
module bdp_front #(
    parameter int MAX_SRC_DIM = bdp_pkg::DEF_MAX_SRC_DIM,
    parameter int MAX_DST_DIM = bdp_pkg::DEF_MAX_DST_DIM,
    parameter int MAX_FACTOR  = bdp_pkg::DEF_MAX_FACTOR
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [31:0]                         source_pixel,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [31:0]                         q_pixel,
    output logic [$clog2(MAX_DST_DIM)-1:0]      q_addr,
    output logic [7:0]                          q_x,
    output logic [7:0]                          q_y,
    output logic [2*$clog2(MAX_FACTOR+1)-1:0]   q_cnt,
    output bdp_pkg::bdp_flags_t                 q_flags
);
    import bdp_pkg::*;

    localparam int SRC_W = $clog2(MAX_SRC_DIM + 1);
    localparam int DST_W = $clog2(MAX_DST_DIM + 1);
    localparam int LW0   = (SRC_W > DST_W) ? SRC_W : DST_W;
    localparam int LW    = (LW0 > SRC_CFG_W) ? LW0 : SRC_CFG_W;
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int AW    = $clog2(MAX_DST_DIM);
    localparam int CW    = 2 * FW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIVX = 6'b000010,
        S_DIVY = 6'b000100,
        S_DIVW = 6'b001000,
        S_DIVH = 6'b010000,
        S_PUSH = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [SRC_CFG_W-1:0] src_w_reg, src_h_reg;
    logic [DST_CFG_W-1:0] dst_w_reg, dst_h_reg;

    logic [LW-1:0] sw, sh, dw, dh;
    logic [31:0]   pix_reg, pix_next;
    logic [LW-1:0] c_reg, c_next, r_reg, r_next, bx_reg, bx_next, by_reg, by_next;
    logic [FW-1:0] cm_reg, cm_next, rm_reg, rm_next, f_reg, f_next;
    logic [LW-1:0] fx_reg, fx_next, uw_reg, uw_next, uh_reg, uh_next;
    logic [LW-1:0] ox_reg, ox_next, oy_reg, oy_next;

    logic          div_start, div_done;
    logic [LW-1:0] div_a, div_b, div_q;
    logic [LW-1:0] fm, uhv, c_inc, r_inc, x_sum, y_sum;
    logic          cwrap, rwrap, in_used, push, pop;

    logic [31:0]   qpix_reg   [2];
    logic [AW-1:0] qaddr_reg  [2];
    logic [7:0]    qx_reg     [2];
    logic [7:0]    qy_reg     [2];
    logic [CW-1:0] qcnt_reg   [2];
    bdp_flags_t    qflags_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    always_comb
    begin
        if (src_w_reg == '0) sw = LW'(1);
        else if (LW'(src_w_reg) > LW'(MAX_SRC_DIM)) sw = LW'(MAX_SRC_DIM);
        else sw = LW'(src_w_reg);
        if (src_h_reg == '0) sh = LW'(1);
        else if (LW'(src_h_reg) > LW'(MAX_SRC_DIM)) sh = LW'(MAX_SRC_DIM);
        else sh = LW'(src_h_reg);
        if (dst_w_reg == '0) dw = LW'(1);
        else if (LW'(dst_w_reg) > LW'(MAX_DST_DIM)) dw = LW'(MAX_DST_DIM);
        else dw = LW'(dst_w_reg);
        if (dst_h_reg == '0) dh = LW'(1);
        else if (LW'(dst_h_reg) > LW'(MAX_DST_DIM)) dh = LW'(MAX_DST_DIM);
        else dh = LW'(dst_h_reg);
    end

    bdp_div #(.NW(LW), .DWD(LW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign cwrap    = c_reg >= sw;
    assign rwrap    = r_reg >= sh;
    assign in_used  = (bx_reg < uw_reg) && (by_reg < uh_reg);
    assign c_inc    = c_reg + 1'b1;
    assign r_inc    = r_reg + 1'b1;
    assign x_sum    = ox_reg + bx_reg;
    assign y_sum    = oy_reg + by_reg;

    always_comb
    begin
        state_next = state_reg;
        pix_next   = pix_reg;
        c_next     = c_reg;
        r_next     = r_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        cm_next    = cm_reg;
        rm_next    = rm_reg;
        f_next     = f_reg;
        fx_next    = fx_reg;
        uw_next    = uw_reg;
        uh_next    = uh_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        div_start  = 1'b0;
        div_a      = sw;
        div_b      = dw;
        push       = 1'b0;
        fm         = (fx_reg > div_q) ? fx_reg : div_q;
        if (fm == '0) fm = LW'(1);
        if (fm > LW'(MAX_FACTOR)) fm = LW'(MAX_FACTOR);
        uhv        = (div_q > dh) ? dh : div_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next = source_pixel;
                    if (cwrap)
                    begin
                        c_next  = '0;
                        bx_next = '0;
                        cm_next = '0;
                    end
                    if (rwrap)
                    begin
                        r_next  = '0;
                        by_next = '0;
                        rm_next = '0;
                    end
                    if ((cwrap || c_reg == '0) && (rwrap || r_reg == '0))
                    begin
                        state_next = S_DIVX;
                        div_start  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    fx_next    = div_q;
                    div_start  = 1'b1;
                    div_a      = sh;
                    div_b      = dh;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    f_next     = fm[FW-1:0];
                    div_start  = 1'b1;
                    div_a      = sw;
                    div_b      = fm;
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    uw_next    = (div_q > dw) ? dw : div_q;
                    div_start  = 1'b1;
                    div_a      = sh;
                    div_b      = LW'(f_reg);
                    state_next = S_DIVH;
                end
            end
            S_DIVH:
            begin
                if (div_done)
                begin
                    uh_next    = uhv;
                    ox_next    = (dw - uw_reg) >> 1;
                    oy_next    = (dh - uhv) >> 1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!in_used || cnt_reg != 2'd2)
                begin
                    push       = in_used;
                    state_next = S_IDLE;
                    if (c_inc >= sw)
                    begin
                        c_next  = '0;
                        bx_next = '0;
                        cm_next = '0;
                        if (r_inc >= sh)
                        begin
                            r_next  = '0;
                            by_next = '0;
                            rm_next = '0;
                        end
                        else
                        begin
                            r_next = r_inc;
                            if (rm_reg == f_reg - 1'b1)
                            begin
                                rm_next = '0;
                                by_next = by_reg + 1'b1;
                            end
                            else
                            begin
                                rm_next = rm_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        c_next = c_inc;
                        if (cm_reg == f_reg - 1'b1)
                        begin
                            cm_next = '0;
                            bx_next = bx_reg + 1'b1;
                        end
                        else
                        begin
                            cm_next = cm_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_pixel = qpix_reg[rp_reg];
    assign q_addr  = qaddr_reg[rp_reg];
    assign q_x     = qx_reg[rp_reg];
    assign q_y     = qy_reg[rp_reg];
    assign q_cnt   = qcnt_reg[rp_reg];
    assign q_flags = qflags_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_w_reg <= SRC_DIM_RESET;
            src_h_reg <= SRC_DIM_RESET;
            dst_w_reg <= DST_DIM_RESET;
            dst_h_reg <= DST_DIM_RESET;
            c_reg     <= '0;
            r_reg     <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            cm_reg    <= '0;
            rm_reg    <= '0;
            f_reg     <= FW'(1);
            fx_reg    <= '0;
            uw_reg    <= '0;
            uh_reg    <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            r_reg     <= r_next;
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            cm_reg    <= cm_next;
            rm_reg    <= rm_next;
            f_reg     <= f_next;
            fx_reg    <= fx_next;
            uw_reg    <= uw_next;
            uh_reg    <= uh_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            if (cfg_we)
            begin
                unique case (bdp_reg_t'(cfg_index))
                    REG_SRC_WIDTH:  src_w_reg <= cfg_wdata[SRC_CFG_W-1:0];
                    REG_SRC_HEIGHT: src_h_reg <= cfg_wdata[SRC_CFG_W-1:0];
                    REG_DST_WIDTH:  dst_w_reg <= cfg_wdata[DST_CFG_W-1:0];
                    REG_DST_HEIGHT: dst_h_reg <= cfg_wdata[DST_CFG_W-1:0];
                    default:        src_w_reg <= src_w_reg;
                endcase
            end
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        if (push)
        begin
            qpix_reg[wp_reg]         <= pix_reg;
            qaddr_reg[wp_reg]        <= bx_reg[AW-1:0];
            qx_reg[wp_reg]           <= x_sum[7:0];
            qy_reg[wp_reg]           <= y_sum[7:0];
            qcnt_reg[wp_reg]         <= CW'(f_reg) * CW'(f_reg);
            qflags_reg[wp_reg].first <= (cm_reg == '0) && (rm_reg == '0);
            qflags_reg[wp_reg].emit  <= (cm_reg == f_reg - 1'b1) && (rm_reg == f_reg - 1'b1);
            qflags_reg[wp_reg].last  <= (bx_reg == uw_reg - 1'b1) && (by_reg == uh_reg - 1'b1);
        end
    end
endmodule

@@ design/bdp_back.sv @@
// Back end: column accumulation, averaging, premultiply and output register.
`timescale 1ns / 1ps
module bdp_back #(
    parameter int MAX_DST_DIM = bdp_pkg::DEF_MAX_DST_DIM,
    parameter int MAX_FACTOR  = bdp_pkg::DEF_MAX_FACTOR
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic [31:0]                         q_pixel,
    input  logic [$clog2(MAX_DST_DIM)-1:0]      q_addr,
    input  logic [7:0]                          q_x,
    input  logic [7:0]                          q_y,
    input  logic [2*$clog2(MAX_FACTOR+1)-1:0]   q_cnt,
    input  bdp_pkg::bdp_flags_t                 q_flags,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          out_x,
    output logic [7:0]                          out_y,
    output logic [23:0]                         out_pixel,
    output logic                                out_last
);
    import bdp_pkg::*;

    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int CW    = 2 * FW;
    localparam int AW    = $clog2(MAX_DST_DIM);
    localparam int ACC_W = $clog2(MAX_FACTOR * MAX_FACTOR * 255 + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_FIN  = 6'b010000,
        S_OUT  = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [31:0]       pix_reg;
    logic [AW-1:0]     addr_reg;
    logic [7:0]        x_reg, y_reg;
    logic [CW-1:0]     cnt_reg;
    bdp_flags_t        flags_reg;
    logic [7:0]        avg_reg  [4];
    logic [15:0]       prod_reg [3];
    logic [23:0]       pixel_reg;

    logic [4*ACC_W-1:0] rdata, wdata;
    logic [ACC_W-1:0]   quot [4];
    logic [3:0]         done;
    logic               take, ram_we, div_start;

    assign q_ready   = (state_reg == S_IDLE);
    assign take      = q_valid && q_ready;
    assign ram_we    = (state_reg == S_ACC);
    assign div_start = (state_reg == S_ACC) && flags_reg.emit;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            wdata[k*ACC_W +: ACC_W] = flags_reg.first
                ? ACC_W'(pix_reg[k*8 +: 8])
                : rdata[k*ACC_W +: ACC_W] + ACC_W'(pix_reg[k*8 +: 8]);
        end
    end

    bdp_ram #(.WIDTH(4 * ACC_W), .DEPTH(MAX_DST_DIM)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wdata),
        .raddr (q_addr),
        .rdata (rdata)
    );

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        bdp_div #(.NW(ACC_W), .DWD(CW)) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (wdata[k*ACC_W +: ACC_W]),
            .divisor  (cnt_reg),
            .done     (done[k]),
            .quotient (quot[k])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_valid) state_next = S_ACC;
            S_ACC:  state_next = flags_reg.emit ? S_DIV : S_IDLE;
            S_DIV:  if (done[0]) state_next = S_MUL;
            S_MUL:  state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg   <= q_pixel;
            addr_reg  <= q_addr;
            x_reg     <= q_x;
            y_reg     <= q_y;
            cnt_reg   <= q_cnt;
            flags_reg <= q_flags;
        end
        if (state_reg == S_DIV && done[0])
        begin
            for (int k = 0; k < 4; k++)
            begin
                avg_reg[k] <= quot[k][7:0];
            end
        end
        if (state_reg == S_MUL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= {8'd0, avg_reg[k]} * {8'd0, avg_reg[3]};
            end
        end
        if (state_reg == S_FIN)
        begin
            pixel_reg <= {div255(prod_reg[2]), div255(prod_reg[1]), div255(prod_reg[0])};
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_pixel = pixel_reg;
    assign out_last  = flags_reg.last;
endmodule

@@ design/box_downscale_premultiply.sv @@
// Top level of the box-filter downscaler with alpha premultiply.
`timescale 1ns / 1ps
// Source pixels enter in raster order on in_valid/in_ready; averaged, premultiplied
// target pixels leave on out_valid/out_ready with their centred coordinates. The
// front end takes a pixel when idle and queues it in S_PUSH, which waits while the
// queue is full; a frame's first pixel also waits in S_DIVX to S_DIVH while the
// divider settles the scale factor, used size and offsets. The back end reads the
// column store as it takes a pixel and writes it in S_ACC, and for each target pixel
// runs the bit-serial averaging dividers (ACC_W is 16 at the default MAX_FACTOR).
// A two-entry queue between the two lets pixels keep flowing while a result waits.
// The column store is not cleared: the first pixel of each block overwrites it.
module box_downscale_premultiply #(
    parameter int MAX_SRC_DIM = bdp_pkg::DEF_MAX_SRC_DIM,
    parameter int MAX_DST_DIM = bdp_pkg::DEF_MAX_DST_DIM,
    parameter int MAX_FACTOR  = bdp_pkg::DEF_MAX_FACTOR
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    source_pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_x,
    output logic [7:0]                     out_y,
    output logic [23:0]                    out_pixel,
    output logic                           out_last
);
    import bdp_pkg::*;

    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int AW = $clog2(MAX_DST_DIM);

    logic            q_valid, q_ready;
    logic [31:0]     q_pixel;
    logic [AW-1:0]   q_addr;
    logic [7:0]      q_x, q_y;
    logic [2*FW-1:0] q_cnt;
    bdp_flags_t      q_flags;

    bdp_front #(
        .MAX_SRC_DIM (MAX_SRC_DIM),
        .MAX_DST_DIM (MAX_DST_DIM),
        .MAX_FACTOR  (MAX_FACTOR)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_pixel (source_pixel),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_pixel      (q_pixel),
        .q_addr       (q_addr),
        .q_x          (q_x),
        .q_y          (q_y),
        .q_cnt        (q_cnt),
        .q_flags      (q_flags)
    );

    bdp_back #(
        .MAX_DST_DIM (MAX_DST_DIM),
        .MAX_FACTOR  (MAX_FACTOR)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_pixel   (q_pixel),
        .q_addr    (q_addr),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_cnt     (q_cnt),
        .q_flags   (q_flags),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_pixel (out_pixel),
        .out_last  (out_last)
    );
endmodule

@@ test/tb_box_downscale_premultiply.sv @@
// Testbench for the box-filter downscaler with alpha premultiply.
`timescale 1ns / 1ps
module tb_box_downscale_premultiply;
    import bdp_pkg::*;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [23:0] pix;
        logic        last;
    } target_px_t;

    typedef struct {
        logic [31:0] pixel;
        bit          typed;
        target_px_t  res;
    } stim_row_t;

    typedef struct {
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int          count;
    } frame_cfg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [31:0]          source_pixel;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_x;
    logic [7:0]           out_y;
    logic [23:0]          out_pixel;
    logic                 out_last;

    box_downscale_premultiply i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_pixel    (out_pixel),
        .out_last     (out_last)
    );

    // predictor state
    int unsigned reg_sw, reg_sh, reg_dw, reg_dh;
    int unsigned col_sums [256][4];
    int unsigned src_col, src_row, factor, used_w, used_h, off_x, off_y;

    target_px_t pending_px[$];
    int         errors;
    int         idle_mode;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void write_reg(bdp_reg_t idx, int unsigned v);
        case (idx)
            REG_SRC_WIDTH:  reg_sw = v & 11'h7FF;
            REG_SRC_HEIGHT: reg_sh = v & 11'h7FF;
            REG_DST_WIDTH:  reg_dw = v & 9'h1FF;
            REG_DST_HEIGHT: reg_dh = v & 9'h1FF;
            default: ;
        endcase
    endfunction

    function automatic bit downscale_step(logic [31:0] px, output target_px_t res);
        int unsigned sw, sh, dw, dh, c, r, bx, by, cnt, a, fy;
        int unsigned ch [4];
        int unsigned rgb [3];
        bit first, hit;
        sw = clamp_dim(reg_sw, 1024);
        sh = clamp_dim(reg_sh, 1024);
        hit = 0;
        res = '0;
        if (src_col >= sw) src_col = 0;
        if (src_row >= sh) src_row = 0;
        if (src_col == 0 && src_row == 0)
        begin
            dw = clamp_dim(reg_dw, 256);
            dh = clamp_dim(reg_dh, 256);
            factor = sw / dw;
            fy = sh / dh;
            if (fy > factor) factor = fy;
            if (factor == 0) factor = 1;
            if (factor > 16) factor = 16;
            used_w = sw / factor;
            if (used_w > dw) used_w = dw;
            used_h = sh / factor;
            if (used_h > dh) used_h = dh;
            off_x = (dw - used_w) / 2;
            off_y = (dh - used_h) / 2;
        end
        c = src_col;
        r = src_row;
        bx = c / factor;
        by = r / factor;
        if (bx < used_w && by < used_h && bx < 256)
        begin
            first = (c % factor == 0) && (r % factor == 0);
            for (int k = 0; k < 4; k++)
            begin
                ch[k] = (px >> (8 * k)) & 8'hFF;
                col_sums[bx][k] = first ? ch[k] : col_sums[bx][k] + ch[k];
            end
            if (c % factor == factor - 1 && r % factor == factor - 1)
            begin
                cnt = factor * factor;
                a = col_sums[bx][3] / cnt;
                for (int k = 0; k < 3; k++)
                begin
                    rgb[k] = col_sums[bx][k] / cnt * a / 255;
                    if (rgb[k] > 255) rgb[k] = 255;
                end
                res.x = 8'(off_x + bx);
                res.y = 8'(off_y + by);
                res.pix = {rgb[2][7:0], rgb[1][7:0], rgb[0][7:0]};
                res.last = (bx == used_w - 1 && by == used_h - 1);
                hit = 1;
            end
        end
        src_col = c + 1;
        if (src_col >= sw)
        begin
            src_col = 0;
            src_row = r + 1;
            if (src_row >= sh) src_row = 0;
        end
        return hit;
    endfunction

    function automatic bit draw_idle(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic int sender_pct();
        case (idle_mode)
            1: return 66;
            3: return 9;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_pct();
        case (idle_mode)
            2: return 66;
            3: return 9;
            default: return 0;
        endcase
    endfunction

    task automatic send_pixel(logic [31:0] px, bit typed, target_px_t typed_res);
        target_px_t res;
        in_valid <= 1'b1;
        source_pixel <= px;
        do
            @(posedge clk);
        while (!in_ready);
        if (downscale_step(px, res))
            pending_px.push_back(typed ? typed_res : res);
        if (draw_idle(sender_pct()))
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (draw_idle(sender_pct()));
        end
    endtask

    task automatic program_frame(frame_cfg_t fc);
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_SRC_WIDTH;
        cfg_wdata <= fc.sw[CFG_DATA_W-1:0];
        write_reg(REG_SRC_WIDTH, fc.sw);
        @(posedge clk);
        cfg_index <= REG_SRC_HEIGHT;
        cfg_wdata <= fc.sh[CFG_DATA_W-1:0];
        write_reg(REG_SRC_HEIGHT, fc.sh);
        @(posedge clk);
        cfg_index <= REG_DST_WIDTH;
        cfg_wdata <= fc.dw[CFG_DATA_W-1:0];
        write_reg(REG_DST_WIDTH, fc.dw);
        @(posedge clk);
        cfg_index <= REG_DST_HEIGHT;
        cfg_wdata <= fc.dh[CFG_DATA_W-1:0];
        write_reg(REG_DST_HEIGHT, fc.dh);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_pixel();
        logic [31:0] px;
        px = $urandom;
        case ($urandom_range(7, 0))
            0: px[31:24] = 8'hFF;
            1: px[31:24] = 8'h00;
            default: ;
        endcase
        return px;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        target_px_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_px.size() == 0)
            begin
                $error("unexpected transaction x=%0d y=%0d", out_x, out_y);
                errors++;
            end
            else
            begin
                want = pending_px.pop_front();
                if (out_x !== want.x)
                begin
                    $error("out_x expected %0d actual %0d", want.x, out_x);
                    errors++;
                end
                if (out_y !== want.y)
                begin
                    $error("out_y expected %0d actual %0d", want.y, out_y);
                    errors++;
                end
                if (out_pixel !== want.pix)
                begin
                    $error("out_pixel expected %h actual %h", want.pix, out_pixel);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $error("out_last expected %0d actual %0d", want.last, out_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= !draw_idle(receiver_pct());
        end
    end

    initial
    begin
        stim_row_t  dir_rows[$];
        frame_cfg_t frames[$];
        frame_cfg_t fc;
        target_px_t none;

        none = '0;
        errors = 0;
        idle_mode = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_wdata = '0;
        in_valid = 1'b0;
        source_pixel = '0;
        reg_sw = 64;
        reg_sh = 64;
        reg_dw = 32;
        reg_dh = 32;
        foreach (col_sums[i, k]) col_sums[i][k] = 0;
        src_col = 0;
        src_row = 0;
        factor = 1;
        used_w = 0;
        used_h = 0;
        off_x = 0;
        off_y = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 source into one target pixel: one transaction every four pixels
        program_frame('{2, 2, 1, 1, 0});
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{32'hFFFF_FFFF, i == 3, '{8'd0, 8'd0, 24'hFF_FFFF, 1'b1}});
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{32'h0000_0000, i == 3, '{8'd0, 8'd0, 24'h00_0000, 1'b1}});
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{32'h00FF_FFFF, i == 3, '{8'd0, 8'd0, 24'h00_0000, 1'b1}});
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{32'hFF00_0000, i == 3, '{8'd0, 8'd0, 24'h00_0000, 1'b1}});
        dir_rows.push_back('{32'h1234_5678, 1'b0, none});
        dir_rows.push_back('{32'h8080_8080, 1'b0, none});
        dir_rows.push_back('{32'h7F7F_7F7F, 1'b0, none});
        dir_rows.push_back('{32'hDEAD_BEEF, 1'b0, none});
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].pixel, dir_rows[i].typed, dir_rows[i].res);

        frames.push_back('{8, 8, 4, 4, 80});
        frames.push_back('{0, 0, 0, 0, 30});
        frames.push_back('{1024, 1, 256, 256, 30});
        frames.push_back('{256, 4, 511, 511, 120});
        frames.push_back('{16, 17, 1, 1, 100});
        frames.push_back('{13, 10, 5, 3, 120});
        frames.push_back('{2047, 2047, 511, 3, 30});
        frames.push_back('{7, 5, 3, 3, 70});
        foreach (frames[p])
        begin
            fc = frames[p];
            program_frame(fc);
            idle_mode = p % 4;
            for (int i = 0; i < fc.count; i++)
                send_pixel(random_pixel(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_px.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
